>>> rtl/quadrature_counter_velocity_defines.svh
// Assertion macros shared by the quadrature counter RTL.
// Depends on nothing; define NO_ASSERTIONS to drop every check.
`ifndef QUADRATURE_COUNTER_VELOCITY_DEFINES_SVH
`define QUADRATURE_COUNTER_VELOCITY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QCV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QCV_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define QCV_ASSERT(label, clk, rst_n, prop, msg)
`define QCV_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> rtl/qcv_pkg.sv
// Shared types, constants and helper functions of the quadrature counter.
// Used by qcv_div and quadrature_counter_velocity; depends on nothing.
package qcv_pkg;

	localparam int CNT_W  = 32;
	localparam int VEL_W  = 16;
	localparam int DVD_W  = 42;                // |diff * 1000| < 2**41
	localparam int DVS_W  = 32;
	localparam int DIV_STEPS = DVD_W / 2;      // two quotient bits per cycle
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DVD_W-1:0] VEL_SCALE = DVD_W'(1000);

	localparam logic [1:0] CMD_LEFT  = 2'd0;
	localparam logic [1:0] CMD_RIGHT = 2'd1;
	localparam logic [1:0] CMD_VEL   = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Step for {previous A/B, new A/B}.
	localparam logic signed [2:0] STEP_TABLE [16] = '{
		3'sd0, 3'sd1, -3'sd1, 3'sd2, -3'sd1, 3'sd0, 3'sd2, 3'sd1,
		3'sd1, 3'sd2, 3'sd0, -3'sd1, 3'sd2, -3'sd1, 3'sd1, 3'sd0
	};

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LEFT  = 6'b000010,
		ST_LWAIT = 6'b000100,
		ST_RIGHT = 6'b001000,
		ST_RWAIT = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// Clamp a sign and magnitude quotient into the signed 16-bit range.
	function automatic logic [VEL_W-1:0] sat_vel(input logic [DVD_W-1:0] mag,
		input logic neg);
		logic [VEL_W-1:0] res;
		if (neg) begin
			if (mag > DVD_W'(32768))
				res = 16'h8000;
			else
				res = VEL_W'(-mag);
		end else begin
			if (mag > DVD_W'(32767))
				res = 16'h7fff;
			else
				res = mag[VEL_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> rtl/quadrature_counter_velocity.sv
// Top level of the quadrature position counter with velocity estimation.
// Depends on qcv_pkg, qcv_div and quadrature_counter_velocity_defines.svh.
//
// Each input word is a command in s_tuser: a left phase sample, a right edge
// event, a velocity request or a plain read. Every word yields exactly one
// output word with both 32-bit positions. Samples, edge events and reads
// produce their output word in the cycle after they are taken. A velocity
// request with a nonzero time difference runs the shared divider twice, once
// for the left and once for the right velocity, through the states ST_LEFT,
// ST_LWAIT, ST_RIGHT, ST_RWAIT and ST_DONE. The input is not ready while a
// request is being worked on or while a finished word waits in the output
// register.
`include "quadrature_counter_velocity_defines.svh"

module quadrature_counter_velocity (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // phase_ab[1:0], time_ms[33:2], zero fill
	input  logic [1:0]   s_tuser,   // cmd[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // left_count, right_count, left_velocity,
	                                // right_velocity, from bit 0 up
	output logic         m_tuser    // zero_interval
);

	qcv_pkg::state_t                  state_q;
	logic [1:0]                       prev_phase_q;
	logic [qcv_pkg::CNT_W-1:0]        left_pos_q;
	logic [qcv_pkg::CNT_W-1:0]        right_pos_q;
	logic signed [2:0]                pending_q;
	logic [qcv_pkg::CNT_W-1:0]        left_last_q;
	logic [qcv_pkg::CNT_W-1:0]        right_last_q;
	logic [qcv_pkg::CNT_W-1:0]        time_last_q;
	logic [qcv_pkg::CNT_W-1:0]        ldiff_q;
	logic [qcv_pkg::CNT_W-1:0]        rdiff_q;
	logic [qcv_pkg::CNT_W-1:0]        dt_q;
	logic                             neg_q;
	logic [qcv_pkg::VEL_W-1:0]        lvel_q;
	logic                             out_valid_q;
	logic [95:0]                      out_data_q;
	logic                             out_flag_q;

	logic                             accept;
	logic                             out_free;
	logic                             out_set;
	logic [1:0]                       cmd;
	logic [1:0]                       phase;
	logic [qcv_pkg::CNT_W-1:0]        time_ms;
	logic signed [2:0]                step;
	logic [qcv_pkg::CNT_W-1:0]        left_next;
	logic [qcv_pkg::CNT_W-1:0]        right_next;
	logic [qcv_pkg::CNT_W-1:0]        dt_in;
	logic [qcv_pkg::CNT_W-1:0]        sel_diff;
	logic [qcv_pkg::DVD_W-1:0]        prod;
	logic [qcv_pkg::DVD_W-1:0]        prod_mag;
	logic [qcv_pkg::DVS_W-1:0]        dt_mag;
	logic [qcv_pkg::VEL_W-1:0]        vel_sat;
	qcv_pkg::div_req_t                div_req;
	qcv_pkg::div_rsp_t                div_rsp;

	assign cmd     = s_tuser;
	assign phase   = s_tdata[1:0];
	assign time_ms = s_tdata[33:2];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == qcv_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		step       = qcv_pkg::STEP_TABLE[{prev_phase_q, phase}];
		left_next  = left_pos_q;
		right_next = right_pos_q;
		if (cmd == qcv_pkg::CMD_LEFT)
			left_next = left_pos_q + {{(qcv_pkg::CNT_W-3){step[2]}}, step};
		else if (cmd == qcv_pkg::CMD_RIGHT)
			right_next = right_pos_q + {{(qcv_pkg::CNT_W-3){pending_q[2]}}, pending_q};
		dt_in = time_ms - time_last_q;
	end

	// A word is ready at once unless a division has to run first.
	assign out_set = (accept && !(cmd == qcv_pkg::CMD_VEL && dt_in != '0))
	                 || (state_q == qcv_pkg::ST_DONE && out_free);

	// Scaled position difference, taken as sign and magnitude for the divider.
	always_comb begin
		sel_diff = (state_q == qcv_pkg::ST_RIGHT) ? rdiff_q : ldiff_q;
		prod     = {{(qcv_pkg::DVD_W-qcv_pkg::CNT_W){sel_diff[qcv_pkg::CNT_W-1]}}, sel_diff}
		           * qcv_pkg::VEL_SCALE;
		prod_mag = prod[qcv_pkg::DVD_W-1] ? qcv_pkg::DVD_W'(-prod) : prod;
		dt_mag   = dt_q[qcv_pkg::CNT_W-1] ? qcv_pkg::DVS_W'(-dt_q) : dt_q;
		div_req.start    = (state_q == qcv_pkg::ST_LEFT) || (state_q == qcv_pkg::ST_RIGHT);
		div_req.dividend = prod_mag;
		div_req.divisor  = dt_mag;
		vel_sat = qcv_pkg::sat_vel(div_rsp.quotient, neg_q);
	end

	qcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= qcv_pkg::ST_IDLE;
			prev_phase_q <= '0;
			left_pos_q   <= '0;
			right_pos_q  <= '0;
			pending_q    <= '0;
			left_last_q  <= '0;
			right_last_q <= '0;
			time_last_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_set)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				qcv_pkg::ST_IDLE: begin
					if (accept) begin
						case (cmd)
							qcv_pkg::CMD_LEFT: begin
								left_pos_q   <= left_next;
								pending_q    <= step;
								prev_phase_q <= phase;
							end
							qcv_pkg::CMD_RIGHT: begin
								right_pos_q <= right_next;
								pending_q   <= '0;
							end
							qcv_pkg::CMD_VEL: begin
								left_last_q  <= left_pos_q;
								right_last_q <= right_pos_q;
								time_last_q  <= time_ms;
							end
							default: ;
						endcase
						if (cmd == qcv_pkg::CMD_VEL && dt_in != '0)
							state_q <= qcv_pkg::ST_LEFT;
					end
				end
				qcv_pkg::ST_LEFT:  state_q <= qcv_pkg::ST_LWAIT;
				qcv_pkg::ST_LWAIT: begin
					if (div_rsp.done)
						state_q <= qcv_pkg::ST_RIGHT;
				end
				qcv_pkg::ST_RIGHT: state_q <= qcv_pkg::ST_RWAIT;
				qcv_pkg::ST_RWAIT: begin
					if (div_rsp.done)
						state_q <= qcv_pkg::ST_DONE;
				end
				qcv_pkg::ST_DONE: begin
					if (out_free)
						state_q <= qcv_pkg::ST_IDLE;
				end
				default: state_q <= qcv_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload registers; the velocity fields are filled in as the divider finishes.
	always_ff @(posedge clk) begin
		if (accept) begin
			ldiff_q    <= left_pos_q - left_last_q;
			rdiff_q    <= right_pos_q - right_last_q;
			dt_q       <= dt_in;
			out_data_q <= {32'd0, right_next, left_next};
			out_flag_q <= (cmd == qcv_pkg::CMD_VEL) && (dt_in == '0);
		end
		if (div_req.start)
			neg_q <= prod[qcv_pkg::DVD_W-1] ^ dt_q[qcv_pkg::CNT_W-1];
		if (state_q == qcv_pkg::ST_LWAIT && div_rsp.done)
			lvel_q <= vel_sat;
		if (state_q == qcv_pkg::ST_RWAIT && div_rsp.done)
			out_data_q[95:64] <= {vel_sat, lvel_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_flag_q;

	`QCV_ASSERT(a_done_in_wait, clk, arst_n, div_rsp.done |-> (state_q == qcv_pkg::ST_LWAIT || state_q == qcv_pkg::ST_RWAIT), "divider finished outside a wait state")
	`QCV_NEVER(a_busy_when_idle, clk, arst_n, div_rsp.busy && s_tready, "input ready while the divider is busy")
	`QCV_ASSERT(a_zero_vel, clk, arst_n, (m_tvalid && m_tuser) |-> (m_tdata[95:64] == 32'd0), "zero interval word carries a velocity")
	`QCV_ASSERT(a_vel_start, clk, arst_n, (state_q == qcv_pkg::ST_LEFT) |=> div_rsp.busy, "divider did not start for a velocity request")

endmodule

>>> rtl/qcv_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on qcv_pkg; the divisor must be nonzero.
module qcv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  qcv_pkg::div_req_t req,
	output qcv_pkg::div_rsp_t rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [qcv_pkg::STEP_CNT_W-1:0]     count_q;
	logic [qcv_pkg::DVD_W-1:0]          dvd_q;
	logic [qcv_pkg::DVD_W-1:0]          quo_q;
	logic [qcv_pkg::DVS_W-1:0]          dvs_q;
	logic [qcv_pkg::DVS_W-1:0]          rem_q;

	logic [qcv_pkg::DVS_W:0]            r1;
	logic [qcv_pkg::DVS_W:0]            r2;
	logic [qcv_pkg::DVS_W-1:0]          r1_next;
	logic [qcv_pkg::DVS_W-1:0]          r2_next;
	logic                               q1;
	logic                               q2;

	// The remainder always stays below the divisor, so it fits in DVS_W bits.
	always_comb begin
		r1      = {rem_q, dvd_q[qcv_pkg::DVD_W-1]};
		q1      = (r1 >= {1'b0, dvs_q});
		r1_next = q1 ? qcv_pkg::DVS_W'(r1 - {1'b0, dvs_q}) : r1[qcv_pkg::DVS_W-1:0];
		r2      = {r1_next, dvd_q[qcv_pkg::DVD_W-2]};
		q2      = (r2 >= {1'b0, dvs_q});
		r2_next = q2 ? qcv_pkg::DVS_W'(r2 - {1'b0, dvs_q}) : r2[qcv_pkg::DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				if (count_q == qcv_pkg::STEP_CNT_W'(qcv_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[qcv_pkg::DVD_W-3:0], 2'b00};
			rem_q <= r2_next;
			quo_q <= {quo_q[qcv_pkg::DVD_W-3:0], q1, q2};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for quadrature_counter_velocity: phase words, right edge words,
// velocity requests and reads go in, and every output word is checked against a predictor.
// Depends on qcv_pkg for the command codes and on the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int REPORT_LIMIT = 40;

	// Step for {previous A/B, new A/B}.
	localparam int QUAD_STEP [16] = '{0, 1, -1, 2, -1, 0, 2, 1, 1, 2, 0, -1, 2, -1, 1, 0};
	// Gray order of a clean quadrature cycle. The array is its own inverse.
	localparam logic [1:0] GRAY_ORDER [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

	typedef struct {
		logic [31:0] left_count;
		logic [31:0] right_count;
		logic [15:0] left_velocity;
		logic [15:0] right_velocity;
		logic        zero_interval;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tuser;

	// Predictor state.
	logic [1:0]  last_phase;
	logic [31:0] left_pos;
	logic [31:0] right_pos;
	int          held_step;
	logic [31:0] left_at_poll;
	logic [31:0] right_at_poll;
	logic [31:0] time_at_poll;

	reading_t expected_readings[$];

	bit          src_idle;
	bit          sink_idle;
	int          sink_hold;
	int          quiet_cycles;
	int          mismatches;
	int          words_sent;
	int          phase_words;
	int          edge_words;
	int          poll_words;
	int          read_words;
	int          saturated_polls;
	int          zero_polls;
	int          backward_polls;
	logic [31:0] clock_ms;
	int          gray_idx;

	quadrature_counter_velocity DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
	end

	always #5 clk = ~clk;

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] counts_per_second(logic [31:0] now, logic [31:0] was,
		longint span);
		logic [31:0] delta;
		longint      q;
		delta = now - was;
		q = longint'($signed(delta)) * 1000 / span;
		if (q > 32767) begin
			q = 32767;
			saturated_polls++;
		end else if (q < -32768) begin
			q = -32768;
			saturated_polls++;
		end
		return q[15:0];
	endfunction

	function automatic reading_t advance_counter(logic [1:0] cmd, logic [1:0] phase,
		logic [31:0] stamp);
		reading_t    rd;
		logic [31:0] gap;
		longint      span;
		int          s;
		rd.left_velocity = '0;
		rd.right_velocity = '0;
		rd.zero_interval = 1'b0;
		case (cmd)
			qcv_pkg::CMD_LEFT: begin
				s = QUAD_STEP[{last_phase, phase}];
				left_pos = left_pos + 32'(s);
				held_step = s;
				last_phase = phase;
			end
			qcv_pkg::CMD_RIGHT: begin
				right_pos = right_pos + 32'(held_step);
				held_step = 0;
			end
			qcv_pkg::CMD_VEL: begin
				gap = stamp - time_at_poll;
				span = longint'($signed(gap));
				if (span == 0) begin
					rd.zero_interval = 1'b1;
					zero_polls++;
				end else begin
					if (span < 0)
						backward_polls++;
					rd.left_velocity = counts_per_second(left_pos, left_at_poll, span);
					rd.right_velocity = counts_per_second(right_pos, right_at_poll, span);
				end
				left_at_poll = left_pos;
				right_at_poll = right_pos;
				time_at_poll = stamp;
			end
			default: begin
			end
		endcase
		rd.left_count = left_pos;
		rd.right_count = right_pos;
		return rd;
	endfunction

	// Sends one word and records the reading it must produce once it is taken.
	task automatic send_word(logic [1:0] cmd, logic [1:0] phase, logic [31:0] stamp);
		int gap;
		gap = src_idle && ($urandom_range(0, 2) == 0) ? pause_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'b0, stamp, phase};
		do
			@(posedge clk);
		while (!s_tready);
		expected_readings.push_back(advance_counter(cmd, phase, stamp));
		words_sent++;
		case (cmd)
			qcv_pkg::CMD_LEFT:  phase_words++;
			qcv_pkg::CMD_RIGHT: edge_words++;
			qcv_pkg::CMD_VEL:   poll_words++;
			default:            read_words++;
		endcase
	endtask

	task automatic test_reset_state();
		send_word(qcv_pkg::CMD_READ, 2'd3, 32'hffff_ffff);
		// Time zero right after reset is a zero interval.
		send_word(qcv_pkg::CMD_VEL, 2'd0, 32'h0);
	endtask

	task automatic test_step_table();
		// This order visits every pair of previous and new phase once.
		logic [1:0] walk [16] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
			2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
		for (int i = 0; i < 16; i++) begin
			send_word(qcv_pkg::CMD_LEFT, walk[4'(i)], 32'h0);
			if (i == 3 || i == 10)
				send_word(qcv_pkg::CMD_RIGHT, 2'd0, 32'h0);
		end
		// A final edge moves the right count by the step held from the last sample.
		send_word(qcv_pkg::CMD_RIGHT, 2'd0, 32'h0);
	endtask

	task automatic test_velocity_limits();
		send_word(qcv_pkg::CMD_VEL, 2'd0, 32'h1);
		send_word(qcv_pkg::CMD_VEL, 2'd0, 32'hffff_ffff);
		send_word(qcv_pkg::CMD_VEL, 2'd0, 32'h7fff_ffff);
		clock_ms = 32'h7fff_ffff;
	endtask

	// Bursts of quadrature motion with edge events, each closed by a velocity poll.
	task automatic test_random_motion(int n_words, bit src_pause, bit sink_pause);
		int         stop;
		int         burst;
		int         r;
		bit         fwd;
		logic [1:0] ph;
		logic [31:0] dt;
		src_idle = src_pause;
		sink_idle = sink_pause;
		stop = words_sent + n_words;
		while (words_sent < stop) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
			fwd = 1'($urandom_range(0, 1));
			for (int i = 0; i < burst; i++) begin
				r = $urandom_range(0, 19);
				if (r == 0) begin
					ph = 2'($urandom_range(0, 3));
					gray_idx = int'(GRAY_ORDER[ph]);
				end else begin
					gray_idx = (gray_idx + (((r < 3) ^ fwd) ? 1 : 3)) % 4;
					ph = GRAY_ORDER[2'(gray_idx)];
				end
				send_word(qcv_pkg::CMD_LEFT, ph, $urandom);
				if ($urandom_range(0, 3) == 0)
					send_word(qcv_pkg::CMD_RIGHT, 2'($urandom_range(0, 3)), $urandom);
				if ($urandom_range(0, 15) == 0)
					send_word(qcv_pkg::CMD_RIGHT, 2'($urandom_range(0, 3)), $urandom);
			end
			if ($urandom_range(0, 7) == 0)
				send_word(qcv_pkg::CMD_READ, 2'($urandom_range(0, 3)), $urandom);
			r = $urandom_range(0, 19);
			if (r < 13)
				dt = $urandom_range(1, 20);
			else if (r < 15)
				dt = '0;
			else if (r < 17)
				dt = $urandom_range(21, 5000);
			else if (r < 18)
				dt = $urandom;
			else
				dt = -32'($urandom_range(1, 20));
			clock_ms = clock_ms + dt;
			send_word(qcv_pkg::CMD_VEL, 2'($urandom_range(0, 3)), clock_ms);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$error("%s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				$error("output word with no reading expected");
			end else begin
				want = expected_readings.pop_front();
				check_field("left_count", want.left_count, m_tdata[31:0]);
				check_field("right_count", want.right_count, m_tdata[63:32]);
				check_field("left_velocity", 32'(want.left_velocity), 32'(m_tdata[79:64]));
				check_field("right_velocity", 32'(want.right_velocity), 32'(m_tdata[95:80]));
				check_field("zero_interval", 32'(want.zero_interval), 32'(m_tuser));
			end
		end
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else if (sink_idle && $urandom_range(0, 3) == 0) begin
			sink_hold <= pause_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL quadrature_counter_velocity");
				$finish;
			end
		end
	end

	initial begin
		last_phase = '0;
		left_pos = '0;
		right_pos = '0;
		held_step = 0;
		left_at_poll = '0;
		right_at_poll = '0;
		time_at_poll = '0;
		src_idle = 1'b0;
		sink_idle = 1'b0;
		sink_hold = 0;
		quiet_cycles = 0;
		mismatches = 0;
		words_sent = 0;
		phase_words = 0;
		edge_words = 0;
		poll_words = 0;
		read_words = 0;
		saturated_polls = 0;
		zero_polls = 0;
		backward_polls = 0;
		clock_ms = '0;
		gray_idx = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_step_table();
		test_velocity_limits();
		test_random_motion(300, 1'b0, 1'b0);
		test_random_motion(300, 1'b1, 1'b0);
		test_random_motion(300, 1'b0, 1'b1);
		test_random_motion(450, 1'b1, 1'b1);

		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_readings.size() != 0) begin
			mismatches++;
			$error("%0d readings never arrived", expected_readings.size());
		end

		$display("Sent %0d words: %0d phase samples, %0d right edges, %0d polls, %0d reads.",
			words_sent, phase_words, edge_words, poll_words, read_words);
		$display("Polls hit %0d saturated velocities, %0d zero and %0d backward intervals.",
			saturated_polls, zero_polls, backward_polls);
		if (mismatches == 0)
			$display("PASS quadrature_counter_velocity");
		else
			$display("FAIL quadrature_counter_velocity");
		$finish;
	end

endmodule
